// ===== src/apr_pkg.sv =====
// Shared types, widths, register codes and saturation helpers of the affine point/rect mapper.
package apr_pkg;

  localparam int COORD_BITS = 16;
  localparam int COEF_W     = 24;
  localparam int SHIFT_W    = 32;
  localparam int OUT_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Corner coordinates carry one extra bit for origin plus size.
  localparam int CORNER_W = COORD_BITS + 1;
  localparam int PROD_W   = COEF_W + CORNER_W;
  // Two products plus the translation, with headroom.
  localparam int ACC_W    = PROD_W + 3;
  localparam int RES_W    = ACC_W + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_COEF_XX = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_XY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_YX = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_YY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_Y = 3'd5;

  localparam logic signed [RES_W-1:0] SAT_MAX =
    {{(RES_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [RES_W-1:0] SAT_MIN =
    {{(RES_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

  typedef enum logic [1:0] {
    MODE_POINT,
    MODE_DIRECT,
    MODE_BOX
  } mode_e;

  typedef struct packed {
    logic                         action;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] size_w;
    logic signed [COORD_BITS-1:0] size_h;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] out_x;
    logic signed [OUT_W-1:0] out_y;
    logic signed [OUT_W-1:0] out_w;
    logic signed [OUT_W-1:0] out_h;
    logic                    clipped;
  } out_t;

  typedef struct packed {
    logic signed [COEF_W-1:0]  coef_xx;
    logic signed [COEF_W-1:0]  coef_xy;
    logic signed [COEF_W-1:0]  coef_yx;
    logic signed [COEF_W-1:0]  coef_yy;
    logic signed [SHIFT_W-1:0] shift_x;
    logic signed [SHIFT_W-1:0] shift_y;
  } cfg_t;

  // Products of each coefficient with the near (0) and far (1) corner coordinate.
  typedef struct packed {
    mode_e                    mode;
    logic signed [PROD_W-1:0] xx0;
    logic signed [PROD_W-1:0] xx1;
    logic signed [PROD_W-1:0] yx0;
    logic signed [PROD_W-1:0] yx1;
    logic signed [PROD_W-1:0] xy0;
    logic signed [PROD_W-1:0] xy1;
    logic signed [PROD_W-1:0] yy0;
    logic signed [PROD_W-1:0] yy1;
  } prod_t;

  // Two fixed-point values per axis that still need rounding.
  typedef struct packed {
    mode_e                   mode;
    logic signed [ACC_W-1:0] xa;
    logic signed [ACC_W-1:0] xb;
    logic signed [ACC_W-1:0] ya;
    logic signed [ACC_W-1:0] yb;
  } pair_t;

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [RES_W-1:0] v);
    logic signed [RES_W-1:0] c;
    c = v;
    if (v > SAT_MAX) begin
      c = SAT_MAX;
    end else if (v < SAT_MIN) begin
      c = SAT_MIN;
    end
    return c[OUT_W-1:0];
  endfunction

  function automatic logic sat_hit(input logic signed [RES_W-1:0] v);
    return (v > SAT_MAX) || (v < SAT_MIN);
  endfunction

endpackage

// ===== src/apr_mult.sv =====
// Corner setup stage and coefficient multiplier stage of the affine mapper.
module apr_mult (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  apr_pkg::cfg_t cfg_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  apr_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output apr_pkg::prod_t out_data_o
);
  import apr_pkg::*;

  logic                       c_valid_q;
  logic                       c_act_q;
  logic signed [CORNER_W-1:0] c_x0_q, c_x1_q, c_y0_q, c_y1_q;
  logic signed [CORNER_W-1:0] c_x1_d, c_y1_d;
  logic                       c_ready;

  logic  p_valid_q;
  logic  p_ready;
  prod_t p_q, p_d;

  assign c_ready    = !c_valid_q || p_ready;
  assign p_ready    = !p_valid_q || out_ready_i;
  assign in_ready_o = c_ready;

  assign c_x1_d = CORNER_W'(in_data_i.pos_x) + CORNER_W'(in_data_i.size_w);
  assign c_y1_d = CORNER_W'(in_data_i.pos_y) + CORNER_W'(in_data_i.size_h);

  always_comb begin
    if (!c_act_q) begin
      p_d.mode = MODE_POINT;
    end else if ((cfg_i.coef_xy == '0) && (cfg_i.coef_yx == '0)) begin
      p_d.mode = MODE_DIRECT;
    end else begin
      p_d.mode = MODE_BOX;
    end
    p_d.xx0 = cfg_i.coef_xx * c_x0_q;
    p_d.xx1 = cfg_i.coef_xx * c_x1_q;
    p_d.yx0 = cfg_i.coef_yx * c_y0_q;
    p_d.yx1 = cfg_i.coef_yx * c_y1_q;
    p_d.xy0 = cfg_i.coef_xy * c_x0_q;
    p_d.xy1 = cfg_i.coef_xy * c_x1_q;
    p_d.yy0 = cfg_i.coef_yy * c_y0_q;
    p_d.yy1 = cfg_i.coef_yy * c_y1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
      p_valid_q <= 1'b0;
    end else begin
      if (c_ready) begin
        c_valid_q <= in_valid_i;
      end
      if (p_ready) begin
        p_valid_q <= c_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_ready && in_valid_i) begin
      c_act_q <= in_data_i.action;
      c_x0_q  <= CORNER_W'(in_data_i.pos_x);
      c_y0_q  <= CORNER_W'(in_data_i.pos_y);
      c_x1_q  <= c_x1_d;
      c_y1_q  <= c_y1_d;
    end
    if (p_ready && c_valid_q) begin
      p_q <= p_d;
    end
  end

  assign out_valid_o = p_valid_q;
  assign out_data_o  = p_q;

endmodule

// ===== src/apr_box.sv =====
// Corner sum stage and two-level min/max stages that reduce the mapped corners.
module apr_box (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  apr_pkg::cfg_t  cfg_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  apr_pkg::prod_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output apr_pkg::pair_t out_data_o
);
  import apr_pkg::*;

  function automatic logic signed [ACC_W-1:0] min2(input logic signed [ACC_W-1:0] a,
                                                   input logic signed [ACC_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [ACC_W-1:0] max2(input logic signed [ACC_W-1:0] a,
                                                   input logic signed [ACC_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  // Corner sums.
  logic                    s_valid_q, s_ready;
  mode_e                   s_mode_q;
  logic signed [ACC_W-1:0] s_x_q [4];
  logic signed [ACC_W-1:0] s_y_q [4];
  logic signed [ACC_W-1:0] s_x_d [4];
  logic signed [ACC_W-1:0] s_y_d [4];
  logic signed [ACC_W-1:0] s_wx_q, s_wy_q, s_wx_d, s_wy_d;

  // Pairwise min/max.
  logic                    m_valid_q, m_ready;
  mode_e                   m_mode_q;
  logic signed [ACC_W-1:0] m_xlo01_q, m_xhi01_q, m_xlo23_q, m_xhi23_q;
  logic signed [ACC_W-1:0] m_ylo01_q, m_yhi01_q, m_ylo23_q, m_yhi23_q;
  logic signed [ACC_W-1:0] m_xlo01_d, m_xhi01_d, m_ylo01_d, m_yhi01_d;

  // Final reduction.
  logic  f_valid_q, f_ready;
  pair_t f_q, f_d;

  assign s_ready    = !s_valid_q || m_ready;
  assign m_ready    = !m_valid_q || f_ready;
  assign f_ready    = !f_valid_q || out_ready_i;
  assign in_ready_o = s_ready;

  always_comb begin
    s_x_d[0] = ACC_W'(in_data_i.xx0) + ACC_W'(in_data_i.yx0) + ACC_W'(cfg_i.shift_x);
    s_x_d[1] = ACC_W'(in_data_i.xx1) + ACC_W'(in_data_i.yx0) + ACC_W'(cfg_i.shift_x);
    s_x_d[2] = ACC_W'(in_data_i.xx1) + ACC_W'(in_data_i.yx1) + ACC_W'(cfg_i.shift_x);
    s_x_d[3] = ACC_W'(in_data_i.xx0) + ACC_W'(in_data_i.yx1) + ACC_W'(cfg_i.shift_x);
    s_y_d[0] = ACC_W'(in_data_i.xy0) + ACC_W'(in_data_i.yy0) + ACC_W'(cfg_i.shift_y);
    s_y_d[1] = ACC_W'(in_data_i.xy1) + ACC_W'(in_data_i.yy0) + ACC_W'(cfg_i.shift_y);
    s_y_d[2] = ACC_W'(in_data_i.xy1) + ACC_W'(in_data_i.yy1) + ACC_W'(cfg_i.shift_y);
    s_y_d[3] = ACC_W'(in_data_i.xy0) + ACC_W'(in_data_i.yy1) + ACC_W'(cfg_i.shift_y);
    // Scaled size for the direct path: far product minus near product.
    s_wx_d   = ACC_W'(in_data_i.xx1) - ACC_W'(in_data_i.xx0);
    s_wy_d   = ACC_W'(in_data_i.yy1) - ACC_W'(in_data_i.yy0);
  end

  // Points and direct rectangles carry the origin and the scaled size in the low/high slots.
  always_comb begin
    if (s_mode_q == MODE_BOX) begin
      m_xlo01_d = min2(s_x_q[0], s_x_q[1]);
      m_xhi01_d = max2(s_x_q[0], s_x_q[1]);
      m_ylo01_d = min2(s_y_q[0], s_y_q[1]);
      m_yhi01_d = max2(s_y_q[0], s_y_q[1]);
    end else begin
      m_xlo01_d = s_x_q[0];
      m_xhi01_d = s_wx_q;
      m_ylo01_d = s_y_q[0];
      m_yhi01_d = s_wy_q;
    end
  end

  always_comb begin
    f_d.mode = m_mode_q;
    if (m_mode_q == MODE_BOX) begin
      f_d.xa = min2(m_xlo01_q, m_xlo23_q);
      f_d.xb = max2(m_xhi01_q, m_xhi23_q);
      f_d.ya = min2(m_ylo01_q, m_ylo23_q);
      f_d.yb = max2(m_yhi01_q, m_yhi23_q);
    end else begin
      f_d.xa = m_xlo01_q;
      f_d.xb = m_xhi01_q;
      f_d.ya = m_ylo01_q;
      f_d.yb = m_yhi01_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
      m_valid_q <= 1'b0;
      f_valid_q <= 1'b0;
    end else begin
      if (s_ready) begin
        s_valid_q <= in_valid_i;
      end
      if (m_ready) begin
        m_valid_q <= s_valid_q;
      end
      if (f_ready) begin
        f_valid_q <= m_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_ready && in_valid_i) begin
      s_mode_q <= in_data_i.mode;
      s_x_q    <= s_x_d;
      s_y_q    <= s_y_d;
      s_wx_q   <= s_wx_d;
      s_wy_q   <= s_wy_d;
    end
    if (m_ready && s_valid_q) begin
      m_mode_q  <= s_mode_q;
      m_xlo01_q <= m_xlo01_d;
      m_xhi01_q <= m_xhi01_d;
      m_ylo01_q <= m_ylo01_d;
      m_yhi01_q <= m_yhi01_d;
      m_xlo23_q <= min2(s_x_q[2], s_x_q[3]);
      m_xhi23_q <= max2(s_x_q[2], s_x_q[3]);
      m_ylo23_q <= min2(s_y_q[2], s_y_q[3]);
      m_yhi23_q <= max2(s_y_q[2], s_y_q[3]);
    end
    if (f_ready && m_valid_q) begin
      f_q <= f_d;
    end
  end

  assign out_valid_o = f_valid_q;
  assign out_data_o  = f_q;

endmodule

// ===== src/apr_fin.sv =====
// Rounding stage and result stage: size, origin fix-up and saturation of the affine mapper.
module apr_fin #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  apr_pkg::pair_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output apr_pkg::out_t  out_data_o
);
  import apr_pkg::*;

  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);

  // Half away from zero: negative values take one less bias, then floor by shifting.
  function automatic logic signed [ACC_W-1:0] round_fix(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] biased;
    biased = v + HALF - {{(ACC_W-1){1'b0}}, v[ACC_W-1]};
    return biased >>> FRAC_BITS;
  endfunction

  logic                    r_valid_q, r_ready;
  mode_e                   r_mode_q;
  logic signed [ACC_W-1:0] r_xa_q, r_xb_q, r_ya_q, r_yb_q;

  logic                    o_valid_q, o_ready;
  out_t                    o_q, o_d;
  logic signed [RES_W-1:0] xa, xb, ya, yb;
  logic signed [RES_W-1:0] fx, fy, fw, fh;

  assign r_ready    = !r_valid_q || o_ready;
  assign o_ready    = !o_valid_q || out_ready_i;
  assign in_ready_o = r_ready;

  assign xa = RES_W'(r_xa_q);
  assign xb = RES_W'(r_xb_q);
  assign ya = RES_W'(r_ya_q);
  assign yb = RES_W'(r_yb_q);

  always_comb begin
    fx = xa;
    fy = ya;
    fw = '0;
    fh = '0;
    case (r_mode_q)
      MODE_BOX: begin
        fw = xb - xa;
        fh = yb - ya;
      end
      MODE_DIRECT: begin
        // A negative scaled size moves the origin and flips sign.
        if (xb < 0) begin
          fx = xa + xb;
          fw = -xb;
        end else begin
          fw = xb;
        end
        if (yb < 0) begin
          fy = ya + yb;
          fh = -yb;
        end else begin
          fh = yb;
        end
      end
      default: begin
      end
    endcase
    o_d.out_x   = sat_out(fx);
    o_d.out_y   = sat_out(fy);
    o_d.out_w   = sat_out(fw);
    o_d.out_h   = sat_out(fh);
    o_d.clipped = sat_hit(fx) || sat_hit(fy) || sat_hit(fw) || sat_hit(fh);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (r_ready) begin
        r_valid_q <= in_valid_i;
      end
      if (o_ready) begin
        o_valid_q <= r_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (r_ready && in_valid_i) begin
      r_mode_q <= in_data_i.mode;
      r_xa_q   <= round_fix(in_data_i.xa);
      r_xb_q   <= (in_data_i.mode == MODE_BOX) ? round_fix(in_data_i.xb) :
                  (in_data_i.mode == MODE_DIRECT) ? round_fix(in_data_i.xb) : '0;
      r_ya_q   <= round_fix(in_data_i.ya);
      r_yb_q   <= (in_data_i.mode == MODE_POINT) ? '0 : round_fix(in_data_i.yb);
    end
    if (o_ready && r_valid_q) begin
      o_q <= o_d;
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_data_o  = o_q;

endmodule

// ===== src/affine_point_rect_mapper.sv =====
// Top level of the affine point/rectangle mapper: configuration registers and pipeline.
//
// Maps points and rectangles through a 2D affine matrix held in six configuration
// registers. The pipeline has seven register stages (corner setup, multiply, corner
// sums, two min/max levels, rounding, result), and one item is taken every clock cycle
// while nothing stalls. Each stage holds its item while the next one is full and stalled,
// so an input transfer is still accepted while a finished result waits, as long as an
// earlier stage has a free slot. The configuration channel is always ready; write it only
// while no item is in flight, since the stages read the live register values.
module affine_point_rect_mapper #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  apr_pkg::in_t                         in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output apr_pkg::out_t                        out_data_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [apr_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [apr_pkg::CFG_DATA_W-1:0]       cfg_data_i
);
  import apr_pkg::*;

  cfg_t  cfg_q, cfg_d;
  logic  mult_ready, mult_valid, box_ready, box_valid, fin_ready;
  prod_t mult_data;
  pair_t box_data;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_COEF_XX: cfg_d.coef_xx = cfg_data_i[COEF_W-1:0];
        CFG_COEF_XY: cfg_d.coef_xy = cfg_data_i[COEF_W-1:0];
        CFG_COEF_YX: cfg_d.coef_yx = cfg_data_i[COEF_W-1:0];
        CFG_COEF_YY: cfg_d.coef_yy = cfg_data_i[COEF_W-1:0];
        CFG_SHIFT_X: cfg_d.shift_x = cfg_data_i[SHIFT_W-1:0];
        CFG_SHIFT_Y: cfg_d.shift_y = cfg_data_i[SHIFT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coef_xx <= COEF_W'(1) << FRAC_BITS;
      cfg_q.coef_xy <= '0;
      cfg_q.coef_yx <= '0;
      cfg_q.coef_yy <= COEF_W'(1) << FRAC_BITS;
      cfg_q.shift_x <= '0;
      cfg_q.shift_y <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_stall_o = !mult_ready;

  apr_mult u_mult (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (mult_ready),
    .in_data_i   (in_data_i),
    .out_valid_o (mult_valid),
    .out_ready_i (box_ready),
    .out_data_o  (mult_data)
  );

  apr_box u_box (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (mult_valid),
    .in_ready_o  (box_ready),
    .in_data_i   (mult_data),
    .out_valid_o (box_valid),
    .out_ready_i (fin_ready),
    .out_data_o  (box_data)
  );

  apr_fin #(
    .FRAC_BITS (FRAC_BITS)
  ) u_fin (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (box_valid),
    .in_ready_o  (fin_ready),
    .in_data_i   (box_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (!out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== src/apr_checker.sv =====
// Port-level assertions for the affine point/rect mapper and their bind to the top level.
module apr_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_stall_o,
  input apr_pkg::out_t out_data_o,
  input logic          out_valid_o,
  input logic          out_stall_i
);
  import apr_pkg::*;

  // A stalled result stays in place.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or vanished");

  // With the result stage empty, every stage can move, so input is never stalled.
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while the pipeline can advance");

  // Sizes are normalized or clamped, so they never come out negative.
  a_size_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !out_data_o.out_w[OUT_W-1] && !out_data_o.out_h[OUT_W-1])
    else $error("negative width or height on a result");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid during reset");

endmodule

bind affine_point_rect_mapper apr_checker u_apr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_data_o  (out_data_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i)
);

// ===== dv/affine_point_rect_mapper_test.sv =====
// Self-checking testbench of the affine point/rectangle mapper with its own result predictor.
`timescale 1ns / 1ps

module affine_point_rect_mapper_test;
  import apr_pkg::*;

  localparam int FRAC = 16;
  localparam int PIPE_DEPTH = 7;
  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_PHASES = 10;
  localparam int PHASE_ITEMS = 170;
  localparam int REG_COUNT = int'(CFG_SHIFT_Y) + 1;
  localparam longint OUT_HI = (longint'(1) <<< (OUT_W - 1)) - 1;
  localparam longint OUT_LO = -(longint'(1) <<< (OUT_W - 1));

  localparam logic ACT_POINT = 1'b0;
  localparam logic ACT_RECT  = 1'b1;

  // Indexes past the register list; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_SHIFT_Y + 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_SHIFT_Y + 3'd2;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Matrix as the block should hold it.
  longint gain_xx = longint'(1) <<< FRAC;
  longint gain_xy = 0;
  longint gain_yx = 0;
  longint gain_yy = longint'(1) <<< FRAC;
  longint offs_x = 0;
  longint offs_y = 0;

  in_t item_q[$];
  out_t mapped_q[$];
  int pending = 0;
  int err_count = 0;
  int cycle_count = 0;
  int gap_pct = 0;
  int stall_pct = 0;

  affine_point_rect_mapper #(
    .FRAC_BITS(FRAC)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Half away from zero.
  function automatic longint round_q(input longint v);
    longint half;
    half = longint'(1) <<< (FRAC - 1);
    if (v >= 0) begin
      return (v + half) >>> FRAC;
    end
    return -((-v + half) >>> FRAC);
  endfunction

  function automatic logic [OUT_W-1:0] clamp_out(input longint v, inout bit hit);
    if (v > OUT_HI) begin
      v = OUT_HI;
      hit = 1'b1;
    end else if (v < OUT_LO) begin
      v = OUT_LO;
      hit = 1'b1;
    end
    return v[OUT_W-1:0];
  endfunction

  function automatic out_t map_item(input in_t it);
    longint px, py, pw, ph, rx, ry, rw, rh, mx, my, xlo, xhi, ylo, yhi;
    longint cx [4];
    longint cy [4];
    bit hit;
    out_t res;
    px = longint'($signed(it.pos_x));
    py = longint'($signed(it.pos_y));
    pw = longint'($signed(it.size_w));
    ph = longint'($signed(it.size_h));
    rw = 0;
    rh = 0;
    hit = 1'b0;
    xlo = 0;
    xhi = 0;
    ylo = 0;
    yhi = 0;
    if (it.action == ACT_POINT) begin
      rx = round_q(gain_xx * px + gain_yx * py + offs_x);
      ry = round_q(gain_xy * px + gain_yy * py + offs_y);
    end else if (gain_xy == 0 && gain_yx == 0) begin
      rx = round_q(gain_xx * px + offs_x);
      ry = round_q(gain_yy * py + offs_y);
      rw = round_q(gain_xx * pw);
      rh = round_q(gain_yy * ph);
      // A negative extent is flipped by moving the origin.
      if (rw < 0) begin
        rx += rw;
        rw = -rw;
      end
      if (rh < 0) begin
        ry += rh;
        rh = -rh;
      end
    end else begin
      cx[0] = px;      cy[0] = py;
      cx[1] = px + pw; cy[1] = py;
      cx[2] = px + pw; cy[2] = py + ph;
      cx[3] = px;      cy[3] = py + ph;
      for (int i = 0; i < 4; i++) begin
        mx = gain_xx * cx[i] + gain_yx * cy[i] + offs_x;
        my = gain_xy * cx[i] + gain_yy * cy[i] + offs_y;
        if (i == 0 || mx < xlo) xlo = mx;
        if (i == 0 || mx > xhi) xhi = mx;
        if (i == 0 || my < ylo) ylo = my;
        if (i == 0 || my > yhi) yhi = my;
      end
      rx = round_q(xlo);
      ry = round_q(ylo);
      // Size comes from the rounded edges, before any clamping.
      rw = round_q(xhi) - rx;
      rh = round_q(yhi) - ry;
    end
    res.out_x = clamp_out(rx, hit);
    res.out_y = clamp_out(ry, hit);
    res.out_w = clamp_out(rw, hit);
    res.out_h = clamp_out(rh, hit);
    res.clipped = hit;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [OUT_W-1:0] want,
                             input logic [OUT_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      err_count++;
    end
  endtask

  // Sender: the queue feeds transfers, the payload holds while stalled.
  always @(posedge clk or negedge rst_n) begin
    logic nxt_valid;
    in_t nxt_data;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      nxt_valid = in_valid;
      nxt_data = in_data;
      if (in_valid && !in_stall) begin
        mapped_q.push_back(map_item(in_data));
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && item_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
        nxt_valid = 1'b1;
        nxt_data = item_q.pop_front();
      end
      in_valid <= nxt_valid;
      in_data <= nxt_data;
    end
  end

  // Receiver: random stall, every transfer is checked against the oldest prediction.
  always @(posedge clk or negedge rst_n) begin
    out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (mapped_q.size() == 0) begin
          $error("result transfer with no prediction waiting");
          err_count++;
        end else begin
          want = mapped_q.pop_front();
          check_field("out_x", want.out_x, out_data.out_x);
          check_field("out_y", want.out_y, out_data.out_y);
          check_field("out_w", want.out_w, out_data.out_w);
          check_field("out_h", want.out_h, out_data.out_h);
          check_field("clipped", OUT_W'(want.clipped), OUT_W'(out_data.clipped));
          pending--;
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("affine_point_rect_mapper_test failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] word);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= word;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_COEF_XX: gain_xx = longint'($signed(word[COEF_W-1:0]));
      CFG_COEF_XY: gain_xy = longint'($signed(word[COEF_W-1:0]));
      CFG_COEF_YX: gain_yx = longint'($signed(word[COEF_W-1:0]));
      CFG_COEF_YY: gain_yy = longint'($signed(word[COEF_W-1:0]));
      CFG_SHIFT_X: offs_x = longint'($signed(word[SHIFT_W-1:0]));
      CFG_SHIFT_Y: offs_y = longint'($signed(word[SHIFT_W-1:0]));
      default: ;
    endcase
  endtask

  // Coefficient words carry random upper bits unless a value is given in full.
  task automatic apply_setting(input int k);
    logic [CFG_DATA_W-1:0] word [REG_COUNT];
    for (int r = 0; r < REG_COUNT; r++) word[r] = $urandom();
    case (k)
      1: begin
        word[CFG_COEF_XX] = -98304;
        word[CFG_COEF_XY] = 0;
        word[CFG_COEF_YX] = 0;
        word[CFG_COEF_YY] = 147456;
      end
      3: begin
        // Half-unit gains and offsets put many values exactly on a rounding tie.
        word[CFG_COEF_XX] = 32768;
        word[CFG_COEF_XY] = 0;
        word[CFG_COEF_YX] = 0;
        word[CFG_COEF_YY] = -32768;
        word[CFG_SHIFT_X] = 32768;
        word[CFG_SHIFT_Y] = -32768;
      end
      4: begin
        for (int r = 0; r < int'(CFG_SHIFT_X); r++) begin
          word[r] = {8'($urandom()), 24'h7FFFFF};
        end
        word[CFG_SHIFT_X] = 32'h7FFF_FFFF;
        word[CFG_SHIFT_Y] = 32'h7FFF_FFFF;
      end
      5: begin
        for (int r = 0; r < int'(CFG_SHIFT_X); r++) begin
          word[r] = {8'($urandom()), 24'h800000};
        end
        word[CFG_SHIFT_X] = 32'h8000_0000;
        word[CFG_SHIFT_Y] = 32'h8000_0000;
      end
      6: begin
        word[CFG_COEF_XX] = 46341;
        word[CFG_COEF_XY] = 46341;
        word[CFG_COEF_YX] = -46341;
        word[CFG_COEF_YY] = 46341;
        word[CFG_SHIFT_X] = 32'($urandom_range(32'h0100_0000)) - 32'h0080_0000;
        word[CFG_SHIFT_Y] = 32'($urandom_range(32'h0100_0000)) - 32'h0080_0000;
      end
      7: begin
        // Only one cross term set still takes the bounding box path.
        word[CFG_COEF_XX] = 32'($urandom_range(524288)) - 32'd262144;
        word[CFG_COEF_XY] = 0;
        word[CFG_COEF_YX] = 32'($urandom_range(65536, 1));
        word[CFG_COEF_YY] = 32'($urandom_range(524288)) - 32'd262144;
      end
      8: begin
        for (int r = 0; r < int'(CFG_SHIFT_X); r++) begin
          word[r] = 32'($urandom_range(1048576)) - 32'd524288;
        end
        word[CFG_SHIFT_X] = 32'($urandom_range(32'h0200_0000)) - 32'h0100_0000;
        word[CFG_SHIFT_Y] = 32'($urandom_range(32'h0200_0000)) - 32'h0100_0000;
      end
      9: begin
        word[CFG_COEF_XX] = 65536;
        word[CFG_COEF_XY] = 0;
        word[CFG_COEF_YX] = 0;
        word[CFG_COEF_YY] = 65536;
        word[CFG_SHIFT_X] = 0;
        word[CFG_SHIFT_Y] = 0;
      end
      default: ;
    endcase
    for (int r = 0; r < REG_COUNT; r++) write_reg(CFG_IDX_W'(r), word[r]);
    write_reg(CFG_SPARE_LO, $urandom());
    write_reg(CFG_SPARE_HI, $urandom());
  endtask

  task automatic queue_item(input logic act, input logic [COORD_BITS-1:0] x,
                            input logic [COORD_BITS-1:0] y, input logic [COORD_BITS-1:0] w,
                            input logic [COORD_BITS-1:0] h);
    in_t it;
    it.action = act;
    it.pos_x = x;
    it.pos_y = y;
    it.size_w = w;
    it.size_h = h;
    item_q.push_back(it);
    pending++;
  endtask

  // Mix of full-range, near-zero and extreme coordinates.
  function automatic logic [COORD_BITS-1:0] rand_coord();
    case ($urandom_range(3))
      0, 1: return COORD_BITS'($urandom());
      2: return COORD_BITS'($urandom_range(16)) - COORD_BITS'(8);
      default: begin
        case ($urandom_range(3))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
    endcase
  endfunction

  task automatic settle();
    while (pending != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int k = 0; k < NUM_PHASES; k++) begin
      if (k != 0) begin
        apply_setting(k);
      end
      if (k < 4) begin
        gap_pct = 29;
        stall_pct = 70;
      end else if (k < 7) begin
        gap_pct = 70;
        stall_pct = 29;
      end else begin
        gap_pct = 0;
        stall_pct = 0;
      end
      if (k == 0) begin
        // Reset matrix: point sizes are ignored, flipped and empty rectangles, extremes.
        queue_item(ACT_POINT, 0, 0, 5, -7);
        queue_item(ACT_POINT, 32767, 32767, 0, 0);
        queue_item(ACT_POINT, -32768, -32768, -1, -1);
        queue_item(ACT_POINT, -1, 1, 32767, -32768);
        queue_item(ACT_RECT, 10, 20, 30, 40);
        queue_item(ACT_RECT, 10, 20, -30, -40);
        queue_item(ACT_RECT, 5, 5, 0, 0);
        queue_item(ACT_RECT, 32767, 32767, 32767, 32767);
        queue_item(ACT_RECT, -32768, -32768, -32768, -32768);
        queue_item(ACT_RECT, -32768, 32767, 32767, -32768);
      end
      repeat (PHASE_ITEMS) begin
        queue_item($urandom_range(1) ? ACT_RECT : ACT_POINT,
                   rand_coord(), rand_coord(), rand_coord(), rand_coord());
      end
      settle();
    end
    if (err_count == 0) begin
      $display("affine_point_rect_mapper_test passed");
    end else begin
      $display("affine_point_rect_mapper_test failed");
    end
    $finish;
  end

endmodule
